[design/xccd_pkg.sv]
// ----------------------------------------------------------------------------
// xccd_pkg - shared definitions for the XOR-checked command deframer
// Result kinds, register indexes, reset values and the result record type.
// ----------------------------------------------------------------------------
package xccd_pkg;

    // result kinds
    localparam logic [2:0] KIND_CHAR    = 3'd0;
    localparam logic [2:0] KIND_NOTE    = 3'd1;
    localparam logic [2:0] KIND_ACCEPT  = 3'd2;
    localparam logic [2:0] KIND_CHKERR  = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN = 3'd5;
    localparam logic [2:0] KIND_REPLY   = 3'd6;

    // timeout stages
    localparam logic [1:0] STAGE_LEN     = 2'd0;
    localparam logic [1:0] STAGE_PAYLOAD = 2'd1;
    localparam logic [1:0] STAGE_CHECK   = 2'd2;

    // configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_LONG_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_COUNT_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_NOTE_TIMEOUT  = 2'd2;

    localparam logic [15:0] LONG_TIMEOUT_RST  = 16'd3000;
    localparam logic [15:0] COUNT_TIMEOUT_RST = 16'd100;
    localparam logic [15:0] NOTE_TIMEOUT_RST  = 16'd200;

    // frame types
    localparam logic [7:0] TYPE_NULL   = 8'd0;
    localparam logic [7:0] TYPE_COORD  = 8'd1;
    localparam logic [7:0] TYPE_TEXT   = 8'd2;
    localparam logic [7:0] TYPE_MUSIC  = 8'd3;
    localparam logic [7:0] TYPE_LED_A  = 8'd4;
    localparam logic [7:0] TYPE_LED_B  = 8'd5;

    // music frames start their check with this in place of the type byte
    localparam logic [7:0] MUSIC_XOR_SEED = 8'h04;

    // one parsed result; with_replies expands it into three reply beats
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  frame_type;
        logic [7:0]  sequence_res;
        logic [7:0]  item_index;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic [7:0]  value_c;
        logic [7:0]  value_d;
        logic [1:0]  wait_stage;
        logic        with_replies;
    } rec_t;

endpackage

[design/xccd_parser.sv]
// ----------------------------------------------------------------------------
// xccd_parser - frame parser
// Updates the frame state once per accepted beat and produces at most one
// result record per beat.
// ----------------------------------------------------------------------------
module xccd_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic              in_tick,
    input  logic [7:0]        in_byte,
    input  logic [15:0]       long_timeout,
    input  logic [15:0]       count_timeout,
    input  logic [15:0]       note_timeout,
    output logic              rec_push,
    output xccd_pkg::rec_t    rec
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_SEQ, PH_FIXED, PH_LEN, PH_TEXT, PH_NOTES, PH_CHECK
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  items_reg, items_next;
    logic [1:0]  grp_reg, grp_next;
    logic [31:0] held_reg, held_next;
    logic [15:0] wait_reg, wait_next;
    logic [15:0] limit;
    logic [7:0]  fixed_len;

    assign fixed_len = (type_reg == xccd_pkg::TYPE_COORD) ? 8'd4 : 8'd3;

    always_comb begin
        if (type_reg == xccd_pkg::TYPE_MUSIC) begin
            limit = (phase_reg == PH_LEN) ? count_timeout : note_timeout;
        end else begin
            limit = long_timeout;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        seq_next   = seq_reg;
        xor_next   = xor_reg;
        len_next   = len_reg;
        items_next = items_reg;
        grp_next   = grp_reg;
        held_next  = held_reg;
        wait_next  = wait_reg;
        rec_push   = 1'b0;
        rec        = '0;
        if (in_accept && in_tick) begin
            // no window runs while idle or awaiting the sequence byte
            if (phase_reg != PH_IDLE && phase_reg != PH_SEQ) begin
                if (wait_reg < limit) begin
                    wait_next = wait_reg + 16'd1;
                end else begin
                    rec_push   = 1'b1;
                    rec.kind   = xccd_pkg::KIND_TIMEOUT;
                    phase_next = PH_IDLE;
                    if (phase_reg == PH_LEN) begin
                        rec.wait_stage = xccd_pkg::STAGE_LEN;
                    end else if (phase_reg == PH_CHECK) begin
                        rec.wait_stage = xccd_pkg::STAGE_CHECK;
                    end else begin
                        rec.wait_stage = xccd_pkg::STAGE_PAYLOAD;
                    end
                end
            end
        end else if (in_accept) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    type_next  = in_byte;
                    seq_next   = 8'd0;
                    xor_next   = in_byte;
                    wait_next  = 16'd0;
                    phase_next = PH_SEQ;
                end
                PH_SEQ: begin
                    seq_next   = in_byte;
                    wait_next  = 16'd0;
                    held_next  = 32'd0;
                    items_next = 8'd0;
                    grp_next   = 2'd0;
                    xor_next   = xor_reg ^ in_byte;
                    priority if (type_reg == xccd_pkg::TYPE_NULL) begin
                        phase_next = PH_IDLE;
                    end else if (type_reg == xccd_pkg::TYPE_COORD ||
                                 type_reg == xccd_pkg::TYPE_LED_A ||
                                 type_reg == xccd_pkg::TYPE_LED_B) begin
                        phase_next = PH_FIXED;
                    end else if (type_reg == xccd_pkg::TYPE_TEXT) begin
                        phase_next = PH_LEN;
                    end else if (type_reg == xccd_pkg::TYPE_MUSIC) begin
                        xor_next   = xccd_pkg::MUSIC_XOR_SEED ^ in_byte;
                        phase_next = PH_LEN;
                    end else begin
                        phase_next = PH_IDLE;
                        rec_push   = 1'b1;
                        rec.kind   = xccd_pkg::KIND_UNKNOWN;
                    end
                end
                PH_FIXED: begin
                    xor_next   = xor_reg ^ in_byte;
                    held_next  = {held_reg[23:0], in_byte};
                    items_next = items_reg + 8'd1;
                    if (items_next >= fixed_len) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_LEN: begin
                    xor_next  = xor_reg ^ in_byte;
                    len_next  = in_byte;
                    wait_next = 16'd0;
                    if (in_byte == 8'd0) begin
                        phase_next = PH_CHECK;
                    end else if (type_reg == xccd_pkg::TYPE_TEXT) begin
                        phase_next = PH_TEXT;
                    end else begin
                        phase_next = PH_NOTES;
                    end
                end
                PH_TEXT: begin
                    xor_next       = xor_reg ^ in_byte;
                    rec_push       = 1'b1;
                    rec.kind       = xccd_pkg::KIND_CHAR;
                    rec.item_index = items_reg;
                    rec.value_a    = {8'd0, in_byte};
                    items_next     = items_reg + 8'd1;
                    wait_next      = 16'd0;
                    if (items_next >= len_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_NOTES: begin
                    xor_next  = xor_reg ^ in_byte;
                    held_next = {held_reg[23:0], in_byte};
                    if (grp_reg == 2'd3) begin
                        grp_next       = 2'd0;
                        rec_push       = 1'b1;
                        rec.kind       = xccd_pkg::KIND_NOTE;
                        rec.item_index = items_reg;
                        rec.value_a    = held_next[31:16];
                        rec.value_b    = held_next[15:0];
                        items_next     = items_reg + 8'd1;
                        wait_next      = 16'd0;
                        if (items_next >= len_reg) begin
                            phase_next = PH_CHECK;
                        end
                    end else begin
                        grp_next = grp_reg + 2'd1;
                    end
                end
                PH_CHECK: begin
                    rec_push   = 1'b1;
                    phase_next = PH_IDLE;
                    if (in_byte != xor_reg) begin
                        rec.kind = xccd_pkg::KIND_CHKERR;
                    end else begin
                        rec.kind         = xccd_pkg::KIND_ACCEPT;
                        rec.with_replies = 1'b1;
                        if (type_reg == xccd_pkg::TYPE_COORD) begin
                            rec.value_a = {8'd0, held_reg[31:24]};
                            rec.value_b = {8'd0, held_reg[23:16]};
                            rec.value_c = held_reg[15:8];
                            rec.value_d = held_reg[7:0];
                        end else if (type_reg == xccd_pkg::TYPE_LED_A ||
                                     type_reg == xccd_pkg::TYPE_LED_B) begin
                            rec.value_a = {8'd0, held_reg[23:16]};
                            rec.value_b = {8'd0, held_reg[15:8]};
                            rec.value_c = held_reg[7:0];
                        end else begin
                            rec.value_a = {8'd0, len_reg};
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        rec.frame_type   = type_next;
        rec.sequence_res = seq_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            type_reg  <= 8'd0;
            seq_reg   <= 8'd0;
            xor_reg   <= 8'd0;
            len_reg   <= 8'd0;
            items_reg <= 8'd0;
            grp_reg   <= 2'd0;
            held_reg  <= 32'd0;
            wait_reg  <= 16'd0;
        end else begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            seq_reg   <= seq_next;
            xor_reg   <= xor_next;
            len_reg   <= len_next;
            items_reg <= items_next;
            grp_reg   <= grp_next;
            held_reg  <= held_next;
            wait_reg  <= wait_next;
        end
    end

    // a text frame never holds more characters than it declared
    a_text_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_TEXT |-> items_reg < len_reg)
        else $error("text count beyond declared length");

    // a tick inside a window that does not time out leaves the wait counter nonzero
    a_wait_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_tick && phase_reg != PH_IDLE && phase_reg != PH_SEQ &&
         !rec_push) |=> wait_reg != 16'd0)
        else $error("tick in window did not advance wait counter");

    // a non-tick byte in idle always opens a frame
    a_idle_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && !in_tick && phase_reg == PH_IDLE) |=> phase_reg == PH_SEQ)
        else $error("type byte did not open a frame");

endmodule

[design/xccd_emitter.sv]
// ----------------------------------------------------------------------------
// xccd_emitter - result queue and beat expander
// Holds up to two result records and sends each out, an accepted frame as a
// summary beat followed by three reply beats.
// ----------------------------------------------------------------------------
module xccd_emitter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rec_push,
    input  xccd_pkg::rec_t    rec,
    output logic              space,
    output logic              m_valid,
    input  logic              m_ready,
    output xccd_pkg::rec_t    m_rec,
    output logic              m_last
);

    xccd_pkg::rec_t slot_reg [2];
    logic       head_reg, head_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] beat_reg, beat_next;
    logic       tail;
    logic       pop;
    xccd_pkg::rec_t h;

    assign h       = slot_reg[head_reg];
    assign tail    = head_reg ^ count_reg[0];
    assign space   = (count_reg != 2'd2);
    assign m_valid = (count_reg != 2'd0);

    always_comb begin
        m_rec = h;
        m_last = !h.with_replies;
        if (beat_reg != 2'd0) begin
            m_rec              = '0;
            m_rec.kind         = xccd_pkg::KIND_REPLY;
            m_rec.frame_type   = h.frame_type;
            m_rec.sequence_res = h.sequence_res;
            m_last             = (beat_reg == 2'd3);
            unique case (beat_reg)
                2'd1:    m_rec.value_a = {8'd0, h.frame_type};
                2'd2:    m_rec.value_a = {8'd0, h.sequence_res};
                default: m_rec.value_a = {8'd0, h.frame_type ^ h.sequence_res};
            endcase
        end
    end

    assign pop = m_valid && m_ready && m_last;

    always_comb begin
        beat_next  = beat_reg;
        head_next  = head_reg;
        count_next = count_reg + {1'b0, rec_push} - {1'b0, pop};
        if (pop) begin
            beat_next = 2'd0;
            head_next = ~head_reg;
        end else if (m_valid && m_ready) begin
            beat_next = beat_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
            beat_reg  <= 2'd0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            beat_reg  <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_push) begin
            slot_reg[tail] <= rec;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_push |-> count_reg != 2'd2)
        else $error("record pushed into full queue");

    a_reply_only_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_reg != 2'd0 |-> (m_valid && h.with_replies))
        else $error("reply beat without an accepted frame");

endmodule

[design/xor_checked_command_deframer_top.sv]
// ----------------------------------------------------------------------------
// xor_checked_command_deframer_top - serial command deframer with XOR check
// Parses typed frames from received bytes and millisecond ticks, reports
// text characters and notes as they arrive, and checks each known non-null frame
// against its XOR check byte.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata                               | tuser | tlast
//  ---------+-----------+-------------------------------------+-------+------
//  s_       | in        | rx_byte                             | opcode| -
//  m_       | out       | type,seq,index,a,b,c,d,wait_stage   | kind  | last
//  APB      | in/out    | three 16-bit timeout limits at 0,4,8| -     | -
//
//  One beat is taken per cycle while the result queue has space: the parser state
//  updates in a single pass between the input handshake and the two-entry queue.
//  Each beat yields up to one record; an accepted frame expands into four
//  output beats, so output, one beat per ready cycle, sets the rate there.
//  s_tready drops only while both queue entries are occupied.
//  Reset (aresetn low, synchronous) clears the parser to idle, empties the
//  queue and loads the default limits 3000, 100 and 200 ticks.
//  Write the limits only while the block is idle.
//
module xor_checked_command_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [7:0] rx_byte
    input  logic [7:0]  s_tdata,
    // s_tuser: [0] opcode
    input  logic [0:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: [7:0] frame_type, [15:8] sequence_res, [23:16] item_index,
    //          [39:24] value_a, [55:40] value_b, [63:56] value_c,
    //          [71:64] value_d, [73:72] wait_stage, [79:74] zero
    output logic [79:0] m_tdata,
    // m_tuser: [2:0] kind
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] long_timeout_reg;
    logic [15:0] count_timeout_reg;
    logic [15:0] note_timeout_reg;
    logic        cfg_write;
    logic        in_accept;
    logic        rec_push;
    logic        space;
    xccd_pkg::rec_t rec;
    xccd_pkg::rec_t m_rec;

    // ---- configuration port ------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_timeout_reg  <= xccd_pkg::LONG_TIMEOUT_RST;
            count_timeout_reg <= xccd_pkg::COUNT_TIMEOUT_RST;
            note_timeout_reg  <= xccd_pkg::NOTE_TIMEOUT_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                xccd_pkg::REG_LONG_TIMEOUT:  long_timeout_reg  <= pwdata[15:0];
                xccd_pkg::REG_COUNT_TIMEOUT: count_timeout_reg <= pwdata[15:0];
                xccd_pkg::REG_NOTE_TIMEOUT:  note_timeout_reg  <= pwdata[15:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            xccd_pkg::REG_LONG_TIMEOUT:  prdata = {16'd0, long_timeout_reg};
            xccd_pkg::REG_COUNT_TIMEOUT: prdata = {16'd0, count_timeout_reg};
            xccd_pkg::REG_NOTE_TIMEOUT:  prdata = {16'd0, note_timeout_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // ---- input side: hold off only when the result queue is full ----------
    assign s_tready  = space;
    assign in_accept = s_tvalid && s_tready;

    xccd_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_accept     (in_accept),
        .in_tick       (s_tuser[0]),
        .in_byte       (s_tdata),
        .long_timeout  (long_timeout_reg),
        .count_timeout (count_timeout_reg),
        .note_timeout  (note_timeout_reg),
        .rec_push      (rec_push),
        .rec           (rec)
    );

    // ---- output side: queue records and expand accepted frames -----------
    xccd_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rec_push (rec_push),
        .rec      (rec),
        .space    (space),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_rec    (m_rec),
        .m_last   (m_tlast)
    );

    assign m_tuser = m_rec.kind;
    assign m_tdata = {6'd0, m_rec.wait_stage, m_rec.value_d, m_rec.value_c,
                      m_rec.value_b, m_rec.value_a, m_rec.item_index,
                      m_rec.sequence_res, m_rec.frame_type};

endmodule
